FILE: src/ntta_pkg.sv
// ----------------------------------------------------------------------------
// ntta_pkg: shared types, constants and tier geometry
// Hash constants, parse phases and the tier table for the tiered address block.
// ----------------------------------------------------------------------------
package ntta_pkg;

    localparam int unsigned NUM_TIERS = 4;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] TAIL_MUL  = 32'd131;

    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_K     = 8'h6B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Register map: byte address bit 2 selects the register index.
    localparam int unsigned PADDR_W  = 3;
    localparam logic        REG_TIER = 1'b0;

    typedef enum logic [2:0] {
        PH_B,
        PH_L,
        PH_K,
        PH_DOT,
        PH_DIGITS,
        PH_TAIL,
        PH_OTHER
    } phase_t;

    typedef struct packed {
        logic [31:0] macro_keep;
        logic [31:0] micro_keep;
        logic [4:0]  micro_shift;
    } tier_geom_t;

    function automatic tier_geom_t tier_geom(input logic [1:0] idx);
        tier_geom_t g;
        unique case (idx)
            2'd0: g = '{32'h0000_007F, 32'h0000_00FF, 5'd8};
            2'd1: g = '{32'h0000_7FFF, 32'h0000_3FFF, 5'd14};
            2'd2: g = '{32'h003F_FFFF, 32'h001F_FFFF, 5'd21};
            default: g = '{32'h1FFF_FFFF, 32'h1FFF_FFFF, 5'd29};
        endcase
        return g;
    endfunction

endpackage

FILE: src/name_to_tiered_address.sv
// ----------------------------------------------------------------------------
// name_to_tiered_address: streamed name to tiered 32-bit address
// Hashes a name one byte per request and emits its tiered address on the
// request flagged last.
// ----------------------------------------------------------------------------
// Output: the address is registered and appears on m_ in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while the result register is free or being
// drained; the hash updates are constant combinational shift-add networks,
// and the result register frees itself in the same cycle its address is taken.
// Reset: aresetn (synchronous, active low) clears the name state, the tier
// register and the result valid flag.
module name_to_tiered_address
    import ntta_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // name byte requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_character,
    input  logic                s_no_character,
    input  logic                s_last,
    // address results
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_address
);

    logic [2:0]  tier_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] fnv_reg, fnv_next;
    logic [31:0] layer_reg, layer_next;
    logic [31:0] tail_reg, tail_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_address_reg, m_address_next;

    logic        accept;
    logic        take_byte;
    logic        is_digit;
    logic [31:0] char_w;
    logic [31:0] fnv_x;
    logic [31:0] fnv_step;
    logic [31:0] tail_step;
    logic [31:0] layer_step;
    logic        blk_name;
    tier_geom_t  geom;
    tier_geom_t  geom_base;
    logic [31:0] macro_val;
    logic [31:0] micro_val;
    logic [31:0] address_val;

    // ------------------------------------------------------------------
    // Configuration: single tier register, always ready
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIER) ? {29'd0, tier_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tier_reg <= 3'd0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIER)) begin
            tier_reg <= pwdata[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a byte whenever the result register is free or
    // being drained this cycle
    // ------------------------------------------------------------------
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign take_byte = accept && !s_no_character;

    // ------------------------------------------------------------------
    // Hash steps as shift-add networks
    // ------------------------------------------------------------------
    assign char_w   = {24'd0, s_character};
    assign is_digit = (s_character >= CHAR_ZERO) && (s_character <= CHAR_NINE);

    // FNV prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
    assign fnv_x    = fnv_reg ^ char_w;
    assign fnv_step = (fnv_x << 24) + (fnv_x << 8) + (fnv_x << 7)
                    + (fnv_x << 4) + (fnv_x << 1) + fnv_x;

    // times 131 is 2^7 + 2^1 + 1
    assign tail_step  = (tail_reg << 7) + (tail_reg << 1) + tail_reg + char_w;
    // times 10 is 2^3 + 2^1
    assign layer_step = (layer_reg << 3) + (layer_reg << 1) + (char_w - {24'd0, CHAR_ZERO});

    // ------------------------------------------------------------------
    // Parse phase: next state
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_B:      phase_next = (s_character == CHAR_B)   ? PH_L      : PH_OTHER;
            PH_L:      phase_next = (s_character == CHAR_L)   ? PH_K      : PH_OTHER;
            PH_K:      phase_next = (s_character == CHAR_K)   ? PH_DOT    : PH_OTHER;
            PH_DOT:    phase_next = (s_character == CHAR_DOT) ? PH_DIGITS : PH_OTHER;
            PH_DIGITS: phase_next = is_digit ? PH_DIGITS : PH_TAIL;
            PH_TAIL:   phase_next = PH_TAIL;
            PH_OTHER:  phase_next = PH_OTHER;
            default:   phase_next = PH_OTHER;
        endcase
    end

    // ------------------------------------------------------------------
    // Hash and layer updates for one byte
    // ------------------------------------------------------------------
    always_comb begin
        fnv_next   = fnv_step;
        layer_next = layer_reg;
        tail_next  = tail_reg;
        unique case (phase_reg)
            PH_DIGITS: begin
                if (is_digit) begin
                    layer_next = layer_step;
                end else if (s_character != CHAR_DOT) begin
                    // drop only the single separator dot
                    tail_next = tail_step;
                end
            end
            PH_TAIL: tail_next = tail_step;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Address composition from the state after the last byte
    // ------------------------------------------------------------------
    assign blk_name  = (phase_next == PH_DIGITS) || (phase_next == PH_TAIL);
    assign geom      = tier_geom(tier_reg[1:0]);
    assign geom_base = tier_geom(2'd0);

    always_comb begin
        macro_val = 32'd0;
        micro_val = 32'd0;
        if ({29'd0, tier_reg} >= 32'(NUM_TIERS)) begin
            // fallback tier: blk names give the tier-0 macro slot alone
            address_val = blk_name ? (layer_next & geom_base.macro_keep) : 32'd0;
        end else begin
            if (blk_name) begin
                macro_val = layer_next & geom.macro_keep;
                micro_val = tail_next & geom.micro_keep;
            end else begin
                micro_val = fnv_next & geom.micro_keep;
            end
            address_val = (macro_val << geom.micro_shift) | micro_val;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_address_next = m_address_reg;
        if (accept && s_last) begin
            m_valid_next   = 1'b1;
            m_address_next = s_no_character ? 32'd0 : address_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_address_reg <= m_address_next;
    end

    // ------------------------------------------------------------------
    // Name state: advance on a byte, return to reset values when a name ends;
    // hold on a stray empty mark
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last)) begin
            phase_reg <= PH_B;
            fnv_reg   <= FNV_BASIS;
            layer_reg <= 32'd0;
            tail_reg  <= 32'd0;
        end else if (take_byte) begin
            phase_reg <= phase_next;
            fnv_reg   <= fnv_next;
            layer_reg <= layer_next;
            tail_reg  <= tail_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;

endmodule
